### rtl/core/fivc_pkg.sv
// ----------------------------------------------------------------------------
// fivc_pkg
// Types, constants and helper functions shared by the virtual clock modules.
// ----------------------------------------------------------------------------
package fivc_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_CLOCK_MODE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RATE_PERMILLE  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ANCHOR_HOST    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ANCHOR_SESSION = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FAULTS_ENABLED = 3'd4;

  // Clock modes.
  localparam logic MODE_ANCHORED = 1'b0;
  localparam logic MODE_SEALED   = 1'b1;

  // Operation codes.
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Status codes.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  localparam logic [16:0] RATE_UNIT    = 17'd1000;
  localparam logic [15:0] MAX_RATE     = 16'd65535;
  localparam logic [15:0] RATE_RESET   = 16'd1000;
  localparam logic [63:0] HASH_MUL     = 64'h9E37_79B9_7F4A_7C15;
  localparam int unsigned HASH_SHIFT   = 33;
  localparam logic [63:0] U64_MAX      = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] U32_MAX      = 32'hFFFF_FFFF;

  // Reciprocal of RATE_UNIT, ceil(2^36 / 1000). It divides any 26-bit
  // value (a 10-bit remainder above a 16-bit digit) exactly.
  localparam logic [26:0] RATE_RECIP       = 27'd68719477;
  localparam int unsigned RATE_RECIP_SHIFT = 36;

  // Divider step count for the jitter modulo.
  localparam logic [5:0] STEPS_HASH = 6'd31;

  typedef enum logic [1:0] {
    KIND_ADVANCE,
    KIND_SEALED,
    KIND_PRE_ANCHOR,
    KIND_SCALED
  } kind_t;

  // One classified request as it waits between front and back.
  typedef struct packed {
    kind_t        kind;
    logic [63:0]  value;      // advance amount, or host time since the anchor
    logic         faults;
    logic         skew_on;
    logic [15:0]  skew_mag;
    logic         jitter_on;
    logic [15:0]  jitter_mag;
  } entry_t;

  // Configuration that the front needs for classification.
  typedef struct packed {
    logic         clock_mode;
    logic         faults;
    logic [63:0]  anchor_host;
  } front_cfg_t;

  typedef struct packed {
    logic         start;
    logic [63:0]  dividend;   // left aligned, top bit first
    logic [5:0]   steps;
    logic [16:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic         done;
    logic [63:0]  quotient;
    logic [16:0]  remainder;
  } div_rsp_t;

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? U64_MAX : s[63:0];
  endfunction

  function automatic logic [31:0] sat_inc32(input logic [31:0] c);
    return (c == U32_MAX) ? c : c + 32'd1;
  endfunction

endpackage

### rtl/core/fivc_front.sv
// ----------------------------------------------------------------------------
// fivc_front
// Classifies each incoming request and pushes it into the request queue.
// ----------------------------------------------------------------------------
module fivc_front (
  input  logic                 push,
  output logic                 full,
  input  logic                 operation,
  input  logic [63:0]          host_now,
  input  logic [63:0]          advance_amount,
  input  logic                 skew_active,
  input  logic [15:0]          skew_magnitude,
  input  logic                 jitter_active,
  input  logic [15:0]          jitter_magnitude,
  input  fivc_pkg::front_cfg_t cfg,
  input  logic                 q_full,
  output logic                 q_push,
  output fivc_pkg::entry_t     q_entry
);

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    q_entry.faults     = cfg.faults;
    q_entry.skew_on    = cfg.faults && skew_active;
    q_entry.skew_mag   = skew_magnitude;
    q_entry.jitter_on  = cfg.faults && jitter_active && (jitter_magnitude != 16'd0);
    q_entry.jitter_mag = jitter_magnitude;
    q_entry.value      = host_now - cfg.anchor_host;
    if (operation == fivc_pkg::OP_ADVANCE) begin
      q_entry.kind  = fivc_pkg::KIND_ADVANCE;
      q_entry.value = advance_amount;
    end else if (cfg.clock_mode == fivc_pkg::MODE_SEALED) begin
      q_entry.kind = fivc_pkg::KIND_SEALED;
    end else if (host_now < cfg.anchor_host) begin
      q_entry.kind = fivc_pkg::KIND_PRE_ANCHOR;
    end else begin
      q_entry.kind = fivc_pkg::KIND_SCALED;
    end
  end

endmodule

### rtl/core/fivc_queue.sv
// ----------------------------------------------------------------------------
// fivc_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module fivc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  fivc_pkg::entry_t wr_entry,
  output logic             q_full,
  input  logic             rd_en,
  output logic             q_empty,
  output fivc_pkg::entry_t rd_entry
);

  fivc_pkg::entry_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_full   = (count == 2'd2);
  assign q_empty  = (count == 2'd0);
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= !wr_ptr;
      if (rd_en) rd_ptr <= !rd_ptr;
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/fivc_div.sv
// ----------------------------------------------------------------------------
// fivc_div
// Restoring divider, one quotient bit per cycle, dividend taken top bit first.
// ----------------------------------------------------------------------------
module fivc_div (
  input  logic               clk,
  input  logic               rst,
  input  fivc_pkg::div_req_t req,
  output fivc_pkg::div_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic [63:0] dvd;
  logic [63:0] quo;
  logic [16:0] rem;
  logic [16:0] dvs;
  logic [17:0] trial;
  logic [17:0] diff;
  logic        ge;

  assign trial = {rem, dvd[63]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = (trial >= {1'b0, dvs});

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
        dvd  <= req.dividend;
        dvs  <= req.divisor;
        quo  <= 64'd0;
        rem  <= 17'd0;
      end else if (busy) begin
        dvd <= {dvd[62:0], 1'b0};
        quo <= {quo[62:0], ge};
        rem <= ge ? diff[16:0] : trial[16:0];
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/fivc_back.sv
// ----------------------------------------------------------------------------
// fivc_back
// Holds configuration and clock state and carries out one request at a time.
// ----------------------------------------------------------------------------
module fivc_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic [fivc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [63:0]                          cfg_data,
  output fivc_pkg::front_cfg_t                 front_cfg,
  input  logic                                 q_empty,
  input  fivc_pkg::entry_t                     q_entry,
  output logic                                 q_pop,
  output fivc_pkg::div_req_t                   div_req,
  input  fivc_pkg::div_rsp_t                   div_rsp,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [63:0]                          stamp,
  output logic                                 status,
  output logic                                 was_skewed,
  output logic                                 was_jittered,
  output logic [31:0]                          skew_total,
  output logic [31:0]                          jitter_total
);

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_MUL_LO, S_MUL_HI, S_DIV_HI, S_REC_MUL, S_REC_SUB, S_DIV_LO,
    S_COMBINE, S_SCALE, S_FAULT, S_HASH0, S_HASH1, S_HASH2, S_MOD, S_WAIT_MOD,
    S_JITTER, S_FINISH
  } state_t;

  state_t state;

  // Configuration.
  logic        clock_mode;
  logic [15:0] rate_permille;
  logic [63:0] anchor_host;
  logic [63:0] anchor_session;
  logic        faults_enabled;

  // Clock state.
  logic [63:0] sealed_time;
  logic [63:0] last_issued;
  logic        skew_primed;
  logic [31:0] skew_count;
  logic [31:0] jitter_count;

  // Working registers.
  fivc_pkg::entry_t ent;
  logic [47:0] prod_lo;
  logic [47:0] prod_hi;
  logic [47:0] q_hi;
  logic [63:0] acc;
  logic [63:0] base;
  logic [63:0] low_bound;
  logic        jittered;
  logic        out_valid;

  // Division by RATE_UNIT, one 16-bit digit per reciprocal multiply and remainder step.
  logic [63:0] dk_num;
  logic [63:0] dk_quo;
  logic [9:0]  dk_rem;
  logic [25:0] dk_v;
  logic [15:0] dk_q;
  logic [1:0]  dk_cnt;
  logic        pass_lo;

  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic [63:0] mul_c;
  logic [48:0] low_word;
  logic [63:0] skew_stamp;
  logic [25:0] dk_v_in;
  logic [52:0] dk_prod;
  logic [25:0] dk_sub;

  assign front_cfg.clock_mode  = clock_mode;
  assign front_cfg.faults      = faults_enabled;
  assign front_cfg.anchor_host = anchor_host;

  assign empty = !out_valid;
  assign q_pop = (state == S_IDLE) && !q_empty && !out_valid;

  assign mul_a = {32'd0, base[31:0]} * {32'd0, fivc_pkg::HASH_MUL[31:0]};
  assign mul_b = {32'd0, base[31:0]} * {32'd0, fivc_pkg::HASH_MUL[63:32]};
  assign mul_c = {32'd0, base[63:32]} * {32'd0, fivc_pkg::HASH_MUL[31:0]};
  assign low_word = {7'd0, dk_rem, 32'd0} + {1'b0, prod_lo};
  assign skew_stamp = (last_issued < {48'd0, ent.skew_mag}) ? 64'd0
                      : last_issued - {48'd0, ent.skew_mag};

  // The running remainder stays below RATE_UNIT, so each digit quotient
  // fits in 16 bits and the reciprocal product below 2^52.
  assign dk_v_in = {dk_rem, dk_num[63:48]};
  assign dk_prod = {27'd0, dk_v_in} * {26'd0, fivc_pkg::RATE_RECIP};
  assign dk_sub  = dk_v - ({10'd0, dk_q} * {9'd0, fivc_pkg::RATE_UNIT});

  always_comb begin
    div_req.start    = (state == S_MOD);
    div_req.dividend = {acc[63:fivc_pkg::HASH_SHIFT], 33'd0};
    div_req.steps    = fivc_pkg::STEPS_HASH;
    div_req.divisor  = {ent.jitter_mag, 1'b1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      clock_mode     <= fivc_pkg::MODE_SEALED;
      rate_permille  <= fivc_pkg::RATE_RESET;
      anchor_host    <= 64'd0;
      anchor_session <= 64'd0;
      faults_enabled <= 1'b0;
      sealed_time    <= 64'd0;
      last_issued    <= 64'd0;
      skew_primed    <= 1'b1;
      skew_count     <= 32'd0;
      jitter_count   <= 32'd0;
    end else begin
      if (pop && out_valid) out_valid <= 1'b0;

      if (cfg_valid) begin
        unique case (cfg_index)
          fivc_pkg::REG_CLOCK_MODE: begin
            clock_mode   <= cfg_data[0];
            sealed_time  <= 64'd0;
            last_issued  <= 64'd0;
            skew_primed  <= 1'b1;
            skew_count   <= 32'd0;
            jitter_count <= 32'd0;
          end
          fivc_pkg::REG_RATE_PERMILLE: begin
            if (cfg_data[15:0] != 16'd0 && cfg_data[15:0] <= fivc_pkg::MAX_RATE)
              rate_permille <= cfg_data[15:0];
          end
          fivc_pkg::REG_ANCHOR_HOST:    anchor_host    <= cfg_data;
          fivc_pkg::REG_ANCHOR_SESSION: anchor_session <= cfg_data;
          fivc_pkg::REG_FAULTS_ENABLED: faults_enabled <= cfg_data[0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            ent      <= q_entry;
            jittered <= 1'b0;
            state    <= S_DECODE;
          end
        end
        S_DECODE: begin
          unique case (ent.kind)
            fivc_pkg::KIND_ADVANCE: begin
              if (clock_mode == fivc_pkg::MODE_ANCHORED) begin
                status <= fivc_pkg::STATUS_REFUSED;
              end else begin
                status      <= fivc_pkg::STATUS_OK;
                sealed_time <= fivc_pkg::sat_add64(sealed_time, ent.value);
              end
              stamp        <= last_issued;
              was_skewed   <= 1'b0;
              was_jittered <= 1'b0;
              skew_total   <= skew_count;
              jitter_total <= jitter_count;
              out_valid    <= 1'b1;
              state        <= S_IDLE;
            end
            fivc_pkg::KIND_SEALED: begin
              base  <= sealed_time;
              state <= S_FAULT;
            end
            fivc_pkg::KIND_PRE_ANCHOR: begin
              base  <= anchor_session;
              state <= S_FAULT;
            end
            default: begin
              state <= S_MUL_LO;
            end
          endcase
        end
        S_MUL_LO: begin
          prod_lo <= {16'd0, ent.value[31:0]} * {32'd0, rate_permille};
          state   <= S_MUL_HI;
        end
        S_MUL_HI: begin
          prod_hi <= {16'd0, ent.value[63:32]} * {32'd0, rate_permille};
          state   <= S_DIV_HI;
        end
        S_DIV_HI: begin
          dk_num  <= {16'd0, prod_hi};
          dk_quo  <= 64'd0;
          dk_rem  <= 10'd0;
          dk_cnt  <= 2'd0;
          pass_lo <= 1'b0;
          state   <= S_REC_MUL;
        end
        S_REC_MUL: begin
          dk_q   <= dk_prod[fivc_pkg::RATE_RECIP_SHIFT+15:fivc_pkg::RATE_RECIP_SHIFT];
          dk_v   <= dk_v_in;
          dk_num <= {dk_num[47:0], 16'd0};
          state  <= S_REC_SUB;
        end
        S_REC_SUB: begin
          dk_rem <= dk_sub[9:0];
          dk_quo <= {dk_quo[47:0], dk_q};
          dk_cnt <= dk_cnt + 2'd1;
          if (dk_cnt != 2'd3) state <= S_REC_MUL;
          else if (pass_lo) state <= S_COMBINE;
          else state <= S_DIV_LO;
        end
        S_DIV_LO: begin
          // The high remainder joins the low partial product.
          q_hi    <= dk_quo[47:0];
          dk_num  <= {15'd0, low_word};
          dk_quo  <= 64'd0;
          dk_rem  <= 10'd0;
          dk_cnt  <= 2'd0;
          pass_lo <= 1'b1;
          state   <= S_REC_MUL;
        end
        S_COMBINE: begin
          // High quotient beyond 32 bits saturates; otherwise the sum wraps.
          if (q_hi[47:32] != 16'd0) acc <= fivc_pkg::U64_MAX;
          else acc <= {q_hi[31:0], 32'd0} + dk_quo;
          state <= S_SCALE;
        end
        S_SCALE: begin
          base  <= fivc_pkg::sat_add64(anchor_session, acc);
          state <= S_FAULT;
        end
        S_FAULT: begin
          if (ent.faults && !ent.skew_on) skew_primed <= 1'b1;
          if (ent.skew_on && skew_primed) begin
            // A skew stamp leaves last_issued alone and takes no jitter.
            skew_primed  <= 1'b0;
            skew_count   <= fivc_pkg::sat_inc32(skew_count);
            stamp        <= skew_stamp;
            status       <= fivc_pkg::STATUS_OK;
            was_skewed   <= 1'b1;
            was_jittered <= 1'b0;
            skew_total   <= fivc_pkg::sat_inc32(skew_count);
            jitter_total <= jitter_count;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end else if (ent.jitter_on) begin
            state <= S_HASH0;
          end else begin
            state <= S_FINISH;
          end
        end
        S_HASH0: begin
          acc       <= mul_a;
          low_bound <= (base < {48'd0, ent.jitter_mag}) ? 64'd0
                       : base - {48'd0, ent.jitter_mag};
          state     <= S_HASH1;
        end
        S_HASH1: begin
          acc   <= acc + {mul_b[31:0], 32'd0};
          state <= S_HASH2;
        end
        S_HASH2: begin
          acc   <= acc + {mul_c[31:0], 32'd0};
          state <= S_MOD;
        end
        S_MOD: state <= S_WAIT_MOD;
        S_WAIT_MOD: begin
          if (div_rsp.done) state <= S_JITTER;
        end
        S_JITTER: begin
          base         <= fivc_pkg::sat_add64(low_bound, {47'd0, div_rsp.remainder});
          jitter_count <= fivc_pkg::sat_inc32(jitter_count);
          jittered     <= 1'b1;
          state        <= S_FINISH;
        end
        S_FINISH: begin
          if (base < last_issued) begin
            stamp <= last_issued;
          end else begin
            stamp       <= base;
            last_issued <= base;
          end
          status       <= fivc_pkg::STATUS_OK;
          was_skewed   <= 1'b0;
          was_jittered <= jittered;
          skew_total   <= skew_count;
          jitter_total <= jitter_count;
          out_valid    <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/fault_injecting_virtual_clock.sv
// ----------------------------------------------------------------------------
// fault_injecting_virtual_clock
// Millisecond timestamp generator with optional skew and jitter faults.
// ----------------------------------------------------------------------------
// Requests enter through a push/full queue port and results leave through an
// empty/pop queue port; a two-entry request queue sits between the classifying
// front and the executing back, so the producer can keep pushing while a
// finished result waits to be popped. The back works on one request at a time
// and starts the next only after the previous result has been popped. An
// advance is settled in the decode step; a sealed or pre-anchor sample goes
// on to the fault step, where a skew ends it, and otherwise to the finish
// step. An anchored sample that scales host time first forms two partial
// products, then runs two divisions by the rate unit, each done as four
// 16-bit digits with a reciprocal multiply and a remainder step, plus load,
// combine and scale steps. Jitter adds three partial-product hash steps and
// a modulo by the variable spread on the bit-serial divider (31 steps). The
// longest request is an anchored sample with jitter.
// Configuration writes are always taken at once and must be issued only while
// the block holds no request. Writing clock_mode clears the sealed time, the
// last issued stamp and both fault counters and re-arms the skew.
module fault_injecting_virtual_clock (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic                             operation,
  input  logic [63:0]                      host_now,
  input  logic [63:0]                      advance_amount,
  input  logic                             skew_active,
  input  logic [15:0]                      skew_magnitude,
  input  logic                             jitter_active,
  input  logic [15:0]                      jitter_magnitude,
  output logic                             empty,
  input  logic                             pop,
  output logic [63:0]                      stamp,
  output logic                             status,
  output logic                             was_skewed,
  output logic                             was_jittered,
  output logic [31:0]                      skew_total,
  output logic [31:0]                      jitter_total,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fivc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                      cfg_data
);

  fivc_pkg::front_cfg_t front_cfg;
  fivc_pkg::entry_t     wr_entry;
  fivc_pkg::entry_t     rd_entry;
  fivc_pkg::div_req_t   div_req;
  fivc_pkg::div_rsp_t   div_rsp;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_push;
  logic                 q_pop;

  // Register writes never stall.
  assign cfg_ready = 1'b1;

  fivc_front u_front (
    .push             (push),
    .full             (full),
    .operation        (operation),
    .host_now         (host_now),
    .advance_amount   (advance_amount),
    .skew_active      (skew_active),
    .skew_magnitude   (skew_magnitude),
    .jitter_active    (jitter_active),
    .jitter_magnitude (jitter_magnitude),
    .cfg              (front_cfg),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_entry          (wr_entry)
  );

  fivc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_entry (wr_entry),
    .q_full   (q_full),
    .rd_en    (q_pop),
    .q_empty  (q_empty),
    .rd_entry (rd_entry)
  );

  fivc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  fivc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .front_cfg    (front_cfg),
    .q_empty      (q_empty),
    .q_entry      (rd_entry),
    .q_pop        (q_pop),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .empty        (empty),
    .pop          (pop),
    .stamp        (stamp),
    .status       (status),
    .was_skewed   (was_skewed),
    .was_jittered (was_jittered),
    .skew_total   (skew_total),
    .jitter_total (jitter_total)
  );

endmodule

### rtl/core/fivc_checker.sv
// ----------------------------------------------------------------------------
// fivc_checker
// Port-level checks on the virtual clock results, bound to the top level.
// ----------------------------------------------------------------------------
module fivc_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [63:0] stamp,
  input logic        status,
  input logic        was_skewed,
  input logic        was_jittered
);

  // A skewed stamp is never also jittered and never a refusal.
  a_skew_excl: assert property (@(posedge clk) disable iff (rst)
    (!empty && was_skewed) |-> (!was_jittered && status == fivc_pkg::STATUS_OK))
    else $error("skewed result also jittered or refused");

  // A refused advance carries no fault marks.
  a_refuse_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == fivc_pkg::STATUS_REFUSED) |-> (!was_skewed && !was_jittered))
    else $error("refused advance carries fault marks");

  // Nothing is waiting right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result present after reset");

  // A waiting result holds until it is popped.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(stamp)))
    else $error("waiting result changed");

endmodule

bind fault_injecting_virtual_clock fivc_checker u_fivc_checker (
  .clk          (clk),
  .rst          (rst),
  .empty        (empty),
  .pop          (pop),
  .stamp        (stamp),
  .status       (status),
  .was_skewed   (was_skewed),
  .was_jittered (was_jittered)
);

### verif/tb_fault_injecting_virtual_clock.sv
// ----------------------------------------------------------------------------
// tb_fault_injecting_virtual_clock
// Self-checking testbench: drives sample and advance requests with random
// gaps, predicts every stamp in a behavioral model and compares each popped
// result field by field, over several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fault_injecting_virtual_clock;

  typedef struct packed {
    logic        op;
    logic [63:0] host;
    logic [63:0] adv;
    logic        sk_on;
    logic [15:0] sk_mag;
    logic        jt_on;
    logic [15:0] jt_mag;
  } req_t;

  typedef struct packed {
    logic [63:0] stamp;
    logic        status;
    logic        skewed;
    logic        jittered;
    logic [31:0] skew_tot;
    logic [31:0] jitter_tot;
  } stamp_rec_t;

  localparam int LIMIT_CYCLES = 2500000;
  localparam int DRAIN_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic operation = 1'b0;
  logic [63:0] host_now = '0;
  logic [63:0] advance_amount = '0;
  logic skew_active = 1'b0;
  logic [15:0] skew_magnitude = '0;
  logic jitter_active = 1'b0;
  logic [15:0] jitter_magnitude = '0;
  logic empty;
  logic pop = 1'b0;
  logic [63:0] stamp;
  logic status;
  logic was_skewed;
  logic was_jittered;
  logic [31:0] skew_total;
  logic [31:0] jitter_total;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [fivc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  fault_injecting_virtual_clock i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model copy of the configuration and state.
  logic        m_mode;
  logic [15:0] m_rate;
  logic [63:0] m_anchor_host;
  logic [63:0] m_anchor_session;
  logic        m_faults;
  logic [63:0] m_sealed;
  logic [63:0] m_last;
  logic        m_armed;
  logic [31:0] m_skew_cnt;
  logic [31:0] m_jitter_cnt;

  req_t       pending_reqs[$];
  stamp_rec_t expected_stamps[$];
  int  errors = 0;
  int  cycle_count = 0;
  bit  hold_results = 1'b0;

  function automatic void clear_state();
    m_sealed = '0;
    m_last = '0;
    m_armed = 1'b1;
    m_skew_cnt = '0;
    m_jitter_cnt = '0;
  endfunction

  function automatic void model_reg_write(logic [fivc_pkg::CFG_INDEX_W-1:0] idx,
                                          logic [63:0] val);
    case (idx)
      fivc_pkg::REG_CLOCK_MODE: begin
        m_mode = val[0];
        clear_state();
      end
      fivc_pkg::REG_RATE_PERMILLE: if (val[15:0] != 16'd0) m_rate = val[15:0];
      fivc_pkg::REG_ANCHOR_HOST: m_anchor_host = val;
      fivc_pkg::REG_ANCHOR_SESSION: m_anchor_session = val;
      fivc_pkg::REG_FAULTS_ENABLED: m_faults = val[0];
      default: ;
    endcase
  endfunction

  // Scaled time from two partial products: a high quotient beyond 32 bits
  // saturates, otherwise the final sum wraps at 64 bits.
  function automatic logic [63:0] scaled_elapsed(logic [63:0] e, logic [15:0] r);
    logic [63:0] lo_part, hi_part, q_hi, low_word;
    lo_part = {32'd0, e[31:0]} * {48'd0, r};
    hi_part = {32'd0, e[63:32]} * {48'd0, r};
    q_hi = hi_part / 64'd1000;
    low_word = ((hi_part % 64'd1000) << 32) + lo_part;
    if (q_hi > 64'h0000_0000_FFFF_FFFF) return fivc_pkg::U64_MAX;
    return (q_hi << 32) + low_word / 64'd1000;
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? fivc_pkg::U64_MAX : s[63:0];
  endfunction

  function automatic logic [31:0] bump(logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  function automatic stamp_rec_t predict_stamp(req_t r);
    stamp_rec_t o;
    logic [63:0] t, mixed, spread, low;
    o = '0;
    if (r.op == fivc_pkg::OP_ADVANCE) begin
      if (m_mode == fivc_pkg::MODE_ANCHORED) o.status = fivc_pkg::STATUS_REFUSED;
      else m_sealed = add_sat(m_sealed, r.adv);
      t = m_last;
    end else begin
      if (m_mode == fivc_pkg::MODE_SEALED) t = m_sealed;
      else if (r.host < m_anchor_host) t = m_anchor_session;
      else t = add_sat(m_anchor_session, scaled_elapsed(r.host - m_anchor_host, m_rate));
      if (m_faults) begin
        if (!r.sk_on) m_armed = 1'b1;
        else if (m_armed) begin
          m_armed = 1'b0;
          m_skew_cnt = bump(m_skew_cnt);
          t = (m_last < r.sk_mag) ? 64'd0 : m_last - r.sk_mag;
          o.skewed = 1'b1;
        end
      end
      if (!o.skewed) begin
        if (m_faults && r.jt_on && r.jt_mag != 0) begin
          mixed = t * fivc_pkg::HASH_MUL;
          spread = {47'd0, r.jt_mag, 1'b1};
          low = (t < r.jt_mag) ? 64'd0 : t - r.jt_mag;
          t = add_sat(low, (mixed >> fivc_pkg::HASH_SHIFT) % spread);
          m_jitter_cnt = bump(m_jitter_cnt);
          o.jittered = 1'b1;
        end
        if (t < m_last) t = m_last;
        m_last = t;
      end
    end
    o.stamp = t;
    o.skew_tot = m_skew_cnt;
    o.jitter_tot = m_jitter_cnt;
    return o;
  endfunction

  // Driver: pushes pending requests with random gaps. The model runs at
  // the moment a request is accepted, so expectations stay in order.
  int send_gap = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (push && !full) begin
      expected_stamps.push_back(predict_stamp(pending_reqs.pop_front()));
    end
    if (push && full) begin
      // Keep offering the same request until it is accepted.
    end else if (send_gap > 0) begin
      push <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_reqs.size() > 0) begin
      req_t r;
      r = pending_reqs[0];
      push <= 1'b1;
      operation <= r.op;
      host_now <= r.host;
      advance_amount <= r.adv;
      skew_active <= r.sk_on;
      skew_magnitude <= r.sk_mag;
      jitter_active <= r.jt_on;
      jitter_magnitude <= r.jt_mag;
      if ($urandom_range(0, 2) == 0)
        send_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
    end else begin
      push <= 1'b0;
    end
  end

  // Monitor: pops with random stalls and checks every field.
  int pop_gap = 0;
  always @(posedge clk) begin
    if (pop && !empty) begin
      if (expected_stamps.size() == 0) begin
        $display("%0t: unexpected result, stamp %h", $time, stamp);
        errors <= errors + 1;
      end else begin
        stamp_rec_t e;
        e = expected_stamps.pop_front();
        if (e.stamp != stamp || e.status != status || e.skewed != was_skewed ||
            e.jittered != was_jittered || e.skew_tot != skew_total ||
            e.jitter_tot != jitter_total) begin
          $display("%0t: mismatch expected stamp %h st %b sk %b jt %b skt %0d jtt %0d",
                   $time, e.stamp, e.status, e.skewed, e.jittered, e.skew_tot,
                   e.jitter_tot);
          $display("%0t:          actual stamp %h st %b sk %b jt %b skt %0d jtt %0d",
                   $time, stamp, status, was_skewed, was_jittered, skew_total,
                   jitter_total);
          errors <= errors + 1;
        end
      end
    end
    if (hold_results) begin
      pop <= 1'b0;
    end else if (pop_gap > 0) begin
      pop <= 1'b0;
      pop_gap <= pop_gap - 1;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 2) == 0)
        pop_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
    end
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick64();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return fivc_pkg::U64_MAX;
      2: return {32'd0, $urandom()} >> $urandom_range(0, 31);
      default: return rand64();
    endcase
  endfunction

  function automatic req_t random_req(logic adv_mode);
    req_t r;
    r.op = ($urandom_range(0, 3) == 0) ? fivc_pkg::OP_ADVANCE : fivc_pkg::OP_SAMPLE;
    r.host = adv_mode ? rand64() : m_anchor_host + ({32'd0, $urandom()} >> $urandom_range(0, 31));
    if ($urandom_range(0, 4) == 0) r.host = pick64();
    r.adv = ($urandom_range(0, 5) == 0) ? pick64() : {48'd0, 16'($urandom())};
    r.sk_on = ($urandom_range(0, 3) == 0);
    r.sk_mag = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom());
    r.jt_on = $urandom_range(0, 1);
    r.jt_mag = ($urandom_range(0, 5) == 0) ? 16'(($urandom_range(0, 1)) ? 0 : 16'hFFFF)
                                          : 16'($urandom() >> $urandom_range(0, 15));
    return r;
  endfunction

  // Waits until every expected stamp has been popped, then lets the
  // block settle before any register write.
  task automatic drain();
    while (pending_reqs.size() != 0 || push || expected_stamps.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Drives cfg_valid low again after each write before returning, so that
  // back-to-back writes never drive cfg_valid twice in the same step.
  task automatic write_reg(logic [fivc_pkg::CFG_INDEX_W-1:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_reg_write(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic directed_item(logic op, logic [63:0] host, logic [63:0] adv, logic sk,
                               logic [15:0] skm, logic jt, logic [15:0] jtm);
    req_t r;
    r = '{op, host, adv, sk, skm, jt, jtm};
    pending_reqs.push_back(r);
  endtask

  initial begin
    int p;
    logic [2:0] bad_idx;
    m_mode = fivc_pkg::MODE_SEALED;
    m_rate = 16'd1000;
    m_anchor_host = '0;
    m_anchor_session = '0;
    m_faults = 1'b0;
    clear_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: sealed mode with advances, saturation, skew and jitter.
    write_reg(fivc_pkg::REG_FAULTS_ENABLED, 64'd1);
    directed_item(fivc_pkg::OP_SAMPLE, 64'd0, 64'd0, 1'b0, 16'd0, 1'b0, 16'd0);
    directed_item(fivc_pkg::OP_ADVANCE, 64'd0, 64'd5000, 1'b0, 16'd0, 1'b0, 16'd0);
    directed_item(fivc_pkg::OP_SAMPLE, 64'd0, 64'd0, 1'b1, 16'd100, 1'b0, 16'd0);
    directed_item(fivc_pkg::OP_SAMPLE, 64'd0, 64'd0, 1'b1, 16'd100, 1'b0, 16'd0);
    directed_item(fivc_pkg::OP_SAMPLE, 64'd0, 64'd0, 1'b0, 16'd0, 1'b1, 16'hFFFF);
    directed_item(fivc_pkg::OP_SAMPLE, 64'd0, 64'd0, 1'b1, 16'hFFFF, 1'b1, 16'd1);
    directed_item(fivc_pkg::OP_SAMPLE, 64'd0, 64'd0, 1'b0, 16'd0, 1'b1, 16'd0);
    directed_item(fivc_pkg::OP_ADVANCE, 64'd0, fivc_pkg::U64_MAX, 1'b0, 16'd0, 1'b0, 16'd0);
    directed_item(fivc_pkg::OP_ADVANCE, 64'd0, fivc_pkg::U64_MAX, 1'b0, 16'd0, 1'b0, 16'd0);
    directed_item(fivc_pkg::OP_SAMPLE, 64'd0, 64'd0, 1'b0, 16'd0, 1'b1, 16'hFFFF);
    drain();
    // Anchored mode: before the anchor, large scaled time, refused advance.
    write_reg(fivc_pkg::REG_CLOCK_MODE, {63'd0, fivc_pkg::MODE_ANCHORED});
    write_reg(fivc_pkg::REG_ANCHOR_HOST, 64'd1000000);
    write_reg(fivc_pkg::REG_ANCHOR_SESSION, 64'd77);
    write_reg(fivc_pkg::REG_RATE_PERMILLE, 64'd0);
    write_reg(fivc_pkg::REG_RATE_PERMILLE, 64'd65535);
    directed_item(fivc_pkg::OP_SAMPLE, 64'd5, 64'd0, 1'b0, 16'd0, 1'b0, 16'd0);
    directed_item(fivc_pkg::OP_SAMPLE, 64'd1000000, 64'd0, 1'b0, 16'd0, 1'b0, 16'd0);
    directed_item(fivc_pkg::OP_SAMPLE, fivc_pkg::U64_MAX, 64'd0, 1'b0, 16'd0, 1'b0, 16'd0);
    directed_item(fivc_pkg::OP_ADVANCE, 64'd0, 64'd9, 1'b0, 16'd0, 1'b0, 16'd0);
    drain();
    write_reg(fivc_pkg::REG_ANCHOR_SESSION, fivc_pkg::U64_MAX - 64'd10);
    write_reg(fivc_pkg::REG_RATE_PERMILLE, 64'd1);
    directed_item(fivc_pkg::OP_SAMPLE, 64'd2000000, 64'd0, 1'b0, 16'd0, 1'b1, 16'd500);
    directed_item(fivc_pkg::OP_SAMPLE, fivc_pkg::U64_MAX, 64'd0, 1'b0, 16'd0, 1'b1, 16'hFFFF);
    drain();

    // Random phases over several register settings.
    for (p = 0; p < 9; p++) begin
      bad_idx = 3'd5 + 3'($urandom_range(0, 2));
      write_reg(bad_idx, rand64());
      write_reg(fivc_pkg::REG_RATE_PERMILLE, (p == 0) ? 64'd1 : (p == 1) ? 64'd65535 :
                                             {48'd0, 16'($urandom_range(1, 3000))});
      write_reg(fivc_pkg::REG_ANCHOR_HOST, (p == 2) ? 64'd0 :
                                           (p == 3) ? fivc_pkg::U64_MAX : rand64() >> 2);
      write_reg(fivc_pkg::REG_ANCHOR_SESSION, (p == 4) ? fivc_pkg::U64_MAX :
                                              (p == 5) ? 64'd0 : rand64() >> 4);
      write_reg(fivc_pkg::REG_FAULTS_ENABLED, {63'd0, p != 6});
      write_reg(fivc_pkg::REG_CLOCK_MODE, {63'd0, p[0]});
      repeat (150) pending_reqs.push_back(random_req(m_mode));
      if (p == 3) begin
        // Long receiver hold-off while the sender keeps offering.
        hold_results = 1'b1;
        repeat (600) @(posedge clk);
        hold_results = 1'b0;
      end
      drain();
    end

    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/fivc_pkg.sv
rtl/core/fivc_front.sv
rtl/core/fivc_queue.sv
rtl/core/fivc_div.sv
rtl/core/fivc_back.sv
rtl/core/fault_injecting_virtual_clock.sv
rtl/core/fivc_checker.sv
verif/tb_fault_injecting_virtual_clock.sv
